// ===== design/mssb_pkg.sv =====
// Shared types, constants and phase codes for the motor soft-start and brake sequencer.
package mssb_pkg;

  // Fixed-point format of the running speed: 8 integer bits over FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 8;
  localparam int SPD_W     = 8 + FRAC_BITS;

  // Ramp increment of one half in the fixed-point format.
  localparam logic [SPD_W-1:0] RAMP_STEP = SPD_W'(1) << (FRAC_BITS - 1);

  // Direction codes that halve the requested speed.
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_LEFT  = 3'd4;

  // Refresh pulse count that must be exceeded for the brake release phase to end.
  localparam logic [4:0] PULSE_LIMIT = 5'd20;

  // Tick count at which a refresh step or a ramp step falls due.
  localparam logic [1:0] TICK_REFRESH = 2'd3;
  localparam logic [1:0] TICK_RAMP    = 2'd2;

  // Phase codes reported on the result port.
  localparam logic [2:0] PHASE_BRAKE   = 3'd0;
  localparam logic [2:0] PHASE_RELEASE = 3'd1;
  localparam logic [2:0] PHASE_HOLD    = 3'd2;
  localparam logic [2:0] PHASE_RAMP    = 3'd3;
  localparam logic [2:0] PHASE_DECAY   = 3'd4;
  localparam logic [2:0] PHASE_WAIT    = 3'd5;
  localparam logic [2:0] PHASE_REFRESH = 3'd6;

  // One-hot sequencer state.
  typedef enum logic [6:0] {
    ST_BRAKE   = 7'b0000001,
    ST_RELEASE = 7'b0000010,
    ST_HOLD    = 7'b0000100,
    ST_RAMP    = 7'b0001000,
    ST_DECAY   = 7'b0010000,
    ST_WAIT    = 7'b0100000,
    ST_REFRESH = 7'b1000000
  } seq_state_t;

  // One control tick as taken from the input channel.
  typedef struct packed {
    logic [7:0] speed;
    logic [2:0] direction;
    logic       direction_sensed;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       pwm_write;
    logic [7:0] pwm_duty;
    logic       brake_released;
    logic       refresh_write;
    logic       refresh_level;
    logic [2:0] phase;
  } result_t;

  // Handshake between the input register and the result register.
  typedef struct packed {
    logic advance;
    logic out_ready;
  } pipe_ctrl_t;

endpackage

// ===== design/mssb_in_stage.sv =====
// Input register: holds one accepted item until the sequencer step takes it.
module mssb_in_stage import mssb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  logic       out_ready,
  output logic       advance,
  output in_item_t   held_item
);

  logic held_valid;

  // The held item moves on whenever the result register can take its result.
  assign advance  = held_valid && out_ready;
  assign in_stall = held_valid && !out_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  // Payload register, loaded with each arriving item whenever the stage is free or emptying.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== design/mssb_core.sv =====
// Sequencer state and the single-tick step logic that produces one result per item.
module mssb_core import mssb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  in_item_t item,
  output result_t  result
);

  seq_state_t       state, state_next;
  logic [1:0]       tick_count, tick_count_next;
  logic [4:0]       refresh_pulses, refresh_pulses_next;
  logic             refresh_data, refresh_data_next;
  logic [SPD_W-1:0] present_speed, present_speed_next;
  logic [7:0]       goal_speed, goal_speed_next;
  logic             brake_pin, brake_pin_next;

  // Step logic for one tick.
  always_comb begin
    logic [7:0]       spd;
    logic [1:0]       tick_inc;
    logic [4:0]       pulse_inc;
    logic [SPD_W-1:0] goal_fixed;
    logic             pw;
    logic [7:0]       duty;
    logic             rw;
    logic             rl;

    spd = item.speed;
    if (item.direction inside {DIR_RIGHT, DIR_LEFT}) begin
      spd = {1'b0, item.speed[7:1]};
    end
    tick_inc   = tick_count + 2'd1;
    pulse_inc  = refresh_pulses + 5'd1;
    goal_fixed = {goal_speed, {FRAC_BITS{1'b0}}};
    pw         = 1'b0;
    duty       = 8'd0;
    rw         = 1'b0;
    rl         = 1'b0;

    state_next          = state;
    tick_count_next     = tick_count;
    refresh_pulses_next = refresh_pulses;
    refresh_data_next   = refresh_data;
    present_speed_next  = present_speed;
    goal_speed_next     = goal_speed;
    brake_pin_next      = brake_pin;

    case (state)
      ST_DECAY: begin
        tick_count_next = 2'd0;
        if (present_speed != '0) begin
          pw                 = 1'b1;
          duty               = 8'(present_speed >> (FRAC_BITS + 4));
          present_speed_next = present_speed >> 2;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        pw              = 1'b1;
        tick_count_next = 2'd0;
        state_next      = ST_BRAKE;
      end
      ST_BRAKE: begin
        pw             = 1'b1;
        brake_pin_next = 1'b0;
        if (spd != 8'd0) begin
          state_next = ST_RELEASE;
        end else begin
          tick_count_next = 2'd0;
        end
      end
      ST_RELEASE: begin
        // Release the brake and toggle refresh once every third tick.
        brake_pin_next  = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc == TICK_REFRESH) begin
          tick_count_next     = 2'd0;
          refresh_data_next   = !refresh_data;
          refresh_pulses_next = pulse_inc;
          if (pulse_inc > PULSE_LIMIT) begin
            refresh_pulses_next = 5'd0;
            refresh_data_next   = 1'b0;
            if (spd != 8'd0) begin
              state_next      = ST_REFRESH;
              goal_speed_next = spd;
            end else begin
              state_next = ST_DECAY;
            end
          end
        end
        rw = 1'b1;
        rl = refresh_data_next;
      end
      ST_REFRESH: begin
        // Keep toggling until the direction feedback is seen on a third tick.
        tick_count_next   = tick_inc;
        refresh_data_next = !refresh_data;
        if (tick_inc == TICK_REFRESH) begin
          tick_count_next = 2'd0;
          if (item.direction_sensed) begin
            state_next        = ST_RAMP;
            refresh_data_next = 1'b0;
            goal_speed_next   = spd;
          end else begin
            rw = 1'b1;
            rl = !refresh_data;
          end
        end
      end
      ST_RAMP: begin
        // Raise the speed by one half every second tick until the goal is met, or decay once no speed is requested.
        if (spd != 8'd0) begin
          if (present_speed < goal_fixed) begin
            pw              = 1'b1;
            duty            = 8'(present_speed >> (FRAC_BITS + 2));
            tick_count_next = tick_inc;
            if (tick_inc >= TICK_RAMP) begin
              tick_count_next    = 2'd0;
              present_speed_next = present_speed + RAMP_STEP;
            end
          end else begin
            state_next      = ST_HOLD;
            tick_count_next = 2'd0;
          end
        end else begin
          tick_count_next = 2'd0;
          state_next      = ST_DECAY;
        end
      end
      ST_HOLD: begin
        if (spd != 8'd0) begin
          pw   = 1'b1;
          duty = {2'b00, spd[7:2]};
        end else begin
          tick_count_next    = 2'd0;
          present_speed_next = goal_fixed;
          state_next         = ST_DECAY;
        end
      end
      default: begin
      end
    endcase

    result.pwm_write      = pw;
    result.pwm_duty       = duty;
    result.brake_released = brake_pin_next;
    result.refresh_write  = rw;
    result.refresh_level  = rl;
    case (state_next)
      ST_BRAKE:   result.phase = PHASE_BRAKE;
      ST_RELEASE: result.phase = PHASE_RELEASE;
      ST_HOLD:    result.phase = PHASE_HOLD;
      ST_RAMP:    result.phase = PHASE_RAMP;
      ST_DECAY:   result.phase = PHASE_DECAY;
      ST_WAIT:    result.phase = PHASE_WAIT;
      ST_REFRESH: result.phase = PHASE_REFRESH;
      default:    result.phase = PHASE_BRAKE;
    endcase
  end

  // Sequencer state, updated as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_BRAKE;
      tick_count     <= 2'd0;
      refresh_pulses <= 5'd0;
      refresh_data   <= 1'b0;
      present_speed  <= '0;
      goal_speed     <= 8'd0;
      brake_pin      <= 1'b0;
    end else if (advance) begin
      state          <= state_next;
      tick_count     <= tick_count_next;
      refresh_pulses <= refresh_pulses_next;
      refresh_data   <= refresh_data_next;
      present_speed  <= present_speed_next;
      goal_speed     <= goal_speed_next;
      brake_pin      <= brake_pin_next;
    end
  end

endmodule

// ===== design/mssb_out_stage.sv =====
// Result register: holds one result item until the output side takes it.
module mssb_out_stage import mssb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  result_t result,
  output logic    out_ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  // The register can load when empty or when its item is taken this cycle.
  assign out_ready = !out_valid || !out_stall;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= advance;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

// ===== design/motor_soft_start_brake_sequencer.sv =====
// Motor soft-start and brake sequencer: one control tick in, one result item out.
// Each item passes the input register, then the result register that holds its result.
// One item per cycle unless stalled; the sequencer step is one pass of logic between them.
// Stalls on the output hold the result register and back up into the input register.
// Reset (rst, synchronous, active high) empties both registers and puts the sequencer in
// the brake phase with all counters, speeds and pins at zero.
module motor_soft_start_brake_sequencer import mssb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] speed,
  input  logic [2:0] direction,
  input  logic       direction_sensed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       pwm_write,
  output logic [7:0] pwm_duty,
  output logic       brake_released,
  output logic       refresh_write,
  output logic       refresh_level,
  output logic [2:0] phase
);

  in_item_t   in_item;
  in_item_t   held_item;
  result_t    result;
  result_t    out_item;
  logic       advance;
  logic       out_ready;

  assign in_item.speed            = speed;
  assign in_item.direction        = direction;
  assign in_item.direction_sensed = direction_sensed;

  // Input register.
  mssb_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_ready (out_ready),
    .advance   (advance),
    .held_item (held_item)
  );

  // Sequencer step and state.
  mssb_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .result  (result)
  );

  // Result register.
  mssb_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign pwm_write      = out_item.pwm_write;
  assign pwm_duty       = out_item.pwm_duty;
  assign brake_released = out_item.brake_released;
  assign refresh_write  = out_item.refresh_write;
  assign refresh_level  = out_item.refresh_level;
  assign phase          = out_item.phase;

`ifndef NO_ASSERTIONS
  // The input side only waits while a finished result is blocked at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // No duty value appears without a duty write.
  a_duty_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pwm_write) |-> (pwm_duty == 8'd0))
    else $error("duty nonzero without a write");

  // No refresh level appears without a refresh drive.
  a_refresh_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !refresh_write) |-> !refresh_level)
    else $error("refresh level without a refresh write");

  // Refresh is only driven once the brake has been released.
  a_release_pin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && refresh_write) |-> brake_released)
    else $error("refresh driven while braking");
`endif

endmodule
